[rtl/cdfr_pkg.sv]
`default_nettype none
package cdfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 6;
    localparam int MEM_AW      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;

    localparam logic [7:0] CRC8_POLY = 8'h07;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_CRC_BAD  = 3'd2;
    localparam logic [2:0] ST_NO_END   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    localparam logic [1:0] REG_START_MARKER = 2'd0;
    localparam logic [1:0] REG_END_MARKER   = 2'd1;

    // one finished frame or error, handed from parser to emitter
    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] len;
        logic             bank;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/cdfr_front.sv]
`default_nettype none
module cdfr_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [7:0]          i_s_tdata,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output cdfr_pkg::t_cmd           o_q_cmd,
    output cdfr_pkg::t_wr            o_wr,
    input  wire cdfr_pkg::t_release  i_release
);
    import cdfr_pkg::*;

    typedef enum logic [4:0] {
        S_HUNT = 5'b00001,
        S_LEN  = 5'b00010,
        S_DATA = 5'b00100,
        S_CRC  = 5'b01000,
        S_END  = 5'b10000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_start, r_end;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_taken, n_taken;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_crc_rx, n_crc_rx;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;
    logic             accept;
    logic [LEN_W-1:0] taken_inc;

    always_comb begin
        unique case (r_phase) inside
            S_LEN, S_END: o_s_tready = !i_q_full;
            S_DATA:       o_s_tready = !r_busy[r_bank];
            default:      o_s_tready = 1'b1;
        endcase
    end

    assign accept    = i_s_tvalid && o_s_tready;
    assign taken_inc = r_taken + LEN_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_taken  = r_taken;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_bank   = r_bank;
        n_busy   = r_busy;
        o_q_push = 1'b0;
        o_q_cmd  = '{status: ST_OK, len: r_len, bank: r_bank};
        o_wr     = '{en: 1'b0, addr: {r_bank, r_taken[IDX_W-1:0]}, data: i_s_tdata};

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            unique case (r_phase)
                S_HUNT: begin
                    if (i_s_tdata == r_start) begin
                        n_phase = S_LEN;
                    end
                end
                S_LEN: begin
                    if (i_s_tdata > 8'(MAX_PAYLOAD)) begin
                        o_q_push       = 1'b1;
                        o_q_cmd.status = ST_TOO_LONG;
                        n_phase        = S_HUNT;
                    end else begin
                        n_len   = i_s_tdata[LEN_W-1:0];
                        n_taken = '0;
                        n_crc   = '0;
                        n_phase = (i_s_tdata == 8'd0) ? S_CRC : S_DATA;
                    end
                end
                S_DATA: begin
                    o_wr.en = 1'b1;
                    n_crc   = crc8_update(r_crc, i_s_tdata);
                    n_taken = taken_inc;
                    if (taken_inc >= r_len) begin
                        n_phase = S_CRC;
                    end
                end
                S_CRC: begin
                    n_crc_rx = i_s_tdata;
                    n_phase  = S_END;
                end
                S_END: begin
                    o_q_push = 1'b1;
                    if (i_s_tdata != r_end) begin
                        o_q_cmd.status = ST_NO_END;
                    end else if (r_crc_rx != r_crc) begin
                        o_q_cmd.status = ST_CRC_BAD;
                    end else if (r_len != '0) begin
                        // bank now belongs to the emitter until it releases it
                        n_busy[r_bank] = 1'b1;
                        n_bank         = !r_bank;
                    end
                    n_phase = S_HUNT;
                end
                default: n_phase = S_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= S_HUNT;
            r_start  <= 8'd2;
            r_end    <= 8'd3;
            r_len    <= '0;
            r_taken  <= '0;
            r_crc    <= '0;
            r_crc_rx <= '0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_taken  <= n_taken;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
            if (i_cfg_we && i_cfg_index == REG_START_MARKER) begin
                r_start <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_END_MARKER) begin
                r_end <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cdfr_queue.sv]
`default_nettype none
module cdfr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cdfr_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output cdfr_pkg::t_cmd       o_cmd,
    output logic                 o_full,
    output logic                 o_empty
);
    import cdfr_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cdfr_back.sv]
`default_nettype none
module cdfr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire cdfr_pkg::t_cmd  i_q_cmd,
    output logic                 o_q_pop,
    input  wire cdfr_pkg::t_wr   i_wr,
    output cdfr_pkg::t_release   o_release,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [7:0]           o_m_tdata,
    output logic [2:0]           o_m_tuser,
    output logic                 o_m_tlast
);
    import cdfr_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_DATA = 4'b0100,
        B_STAT = 4'b1000
    } t_bstate;

    // two banks of payload, one being filled while the other drains
    logic [7:0]       mem [MEM_DEPTH];
    logic [7:0]       r_rd_data;
    logic             rd_en;
    logic [MEM_AW-1:0] rd_addr;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] idx_inc;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic [2:0]       r_status, n_status;
    logic             r_last, n_last;
    logic             out_free;

    assign out_free   = !r_valid || i_m_tready;
    assign idx_inc    = r_idx + LEN_W'(1);
    assign rd_addr    = {r_cmd.bank, r_idx[IDX_W-1:0]};
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_status  = r_status;
        n_last    = r_last;
        o_q_pop   = 1'b0;
        rd_en     = 1'b0;
        o_release = '{valid: 1'b0, bank: r_cmd.bank};

        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    if (i_q_cmd.status == ST_OK && i_q_cmd.len != '0) begin
                        n_state = B_READ;
                    end else begin
                        n_state = B_STAT;
                    end
                end
            end
            B_READ: begin
                rd_en   = 1'b1;
                n_state = B_DATA;
            end
            B_DATA: begin
                if (out_free) begin
                    n_valid  = 1'b1;
                    n_byte   = r_rd_data;
                    n_status = ST_BYTE;
                    n_last   = 1'b0;
                    n_idx    = idx_inc;
                    n_state  = (idx_inc == r_cmd.len) ? B_STAT : B_READ;
                end
            end
            B_STAT: begin
                if (out_free) begin
                    n_valid  = 1'b1;
                    n_byte   = 8'd0;
                    n_status = r_cmd.status;
                    n_last   = 1'b1;
                    n_state  = B_IDLE;
                    o_release.valid = (r_cmd.status == ST_OK) && (r_cmd.len != '0);
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_byte   <= n_byte;
        r_status <= n_status;
        r_last   <= n_last;
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

[rtl/crc8_checked_frame_deframer.sv]
`default_nettype none
// CRC-8 checked frame deframer.
// Slave stream: one received link byte per transfer on i_s_tdata. The parser
// hunts for the start marker, then takes length, payload, CRC-8 (poly 0x07,
// init 0, MSB first, over the payload) and the end marker.
// Master stream: o_m_tdata carries a payload byte (zero on status results),
// o_m_tuser the status (0 byte, 1 ok, 2 crc bad, 3 no end marker, 4 too long)
// and o_m_tlast marks the status transfer that closes each frame.
// Config: i_cfg_we with i_cfg_index 0 = start marker, 1 = end marker; other
// indices are ignored. Write only while the block is idle.
// Throughput: the parser takes one byte per cycle while it is not stalled. A
// good frame is drained from a two-bank payload RAM one payload byte at a
// time: a registered RAM read, then the output register, before the next
// byte is read.
// A 2-entry command queue sits between parser and emitter; the parser stalls
// when the queue is full or when the bank it must fill is still draining.
// When the master side stalls, the output register holds its transfer.
// Reset (synchronous, active low) restores markers 2/3, empties the queue
// and puts the parser back to hunting; the payload RAM is not cleared.
module crc8_checked_frame_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [2:0]      o_m_tuser,   // [2:0] frame_status
    output logic            o_m_tlast,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import cdfr_pkg::*;

    logic     q_push, q_pop, q_full, q_empty;
    t_cmd     q_in, q_out;
    t_wr      wr;
    t_release release_bank;

    cdfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in),
        .o_wr        (wr),
        .i_release   (release_bank)
    );

    cdfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cdfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .i_wr       (wr),
        .o_release  (release_bank),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

[sim/crc8_frame_checker.sv]
`timescale 1ns / 1ps
module crc8_frame_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  wire logic [2:0] i_m_tuser,   // [2:0] frame_status
    input  wire logic       i_m_tlast,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output int              o_pending,
    output int              o_errors
);
    import cdfr_pkg::*;

    typedef enum logic [2:0] {
        HUNT,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CRC,
        TAKE_END
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } t_frame_out;

    t_frame_out  out_due_q[$];
    int          mismatches = 0;

    logic [7:0]  start_mk;
    logic [7:0]  end_mk;
    t_rx_phase   phase;
    logic [5:0]  frame_len;
    logic [5:0]  taken;
    logic [7:0]  crc_acc;
    logic [7:0]  crc_rx;
    logic [7:0]  held_payload [MAX_PAYLOAD];

    assign o_errors = mismatches;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int b = 7; b >= 0; b--) begin
            fb = r[7] ^ d[b];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch, %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_result(input logic [7:0] d, input logic [2:0] st, input logic last);
        t_frame_out r;
        r.data   = d;
        r.status = st;
        r.last   = last;
        out_due_q.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] rx);
        case (phase)
            TAKE_LEN: begin
                if (rx > MAX_PAYLOAD) begin
                    queue_result(8'h00, ST_TOO_LONG, 1'b1);
                    phase = HUNT;
                end else begin
                    frame_len = rx[5:0];
                    taken     = '0;
                    crc_acc   = 8'h00;
                    // empty frame goes straight to the CRC byte
                    phase     = (rx == 0) ? TAKE_CRC : TAKE_DATA;
                end
            end
            TAKE_DATA: begin
                if (taken < MAX_PAYLOAD) begin
                    held_payload[taken[4:0]] = rx;
                end
                crc_acc = crc8_next(crc_acc, rx);
                taken   = taken + 6'd1;
                if (taken >= frame_len) begin
                    phase = TAKE_CRC;
                end
            end
            TAKE_CRC: begin
                crc_rx = rx;
                phase  = TAKE_END;
            end
            TAKE_END: begin
                // missing end marker wins over a bad CRC; the byte is swallowed
                if (rx != end_mk) begin
                    queue_result(8'h00, ST_NO_END, 1'b1);
                end else if (crc_rx != crc_acc) begin
                    queue_result(8'h00, ST_CRC_BAD, 1'b1);
                end else begin
                    for (int i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
                        queue_result(held_payload[i], ST_BYTE, 1'b0);
                    end
                    queue_result(8'h00, ST_OK, 1'b1);
                end
                phase = HUNT;
            end
            default: begin
                phase = (rx == start_mk) ? TAKE_LEN : HUNT;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame_out want;
        if (!i_rst_n) begin
            start_mk  = 8'h02;
            end_mk    = 8'h03;
            phase     = HUNT;
            frame_len = '0;
            taken     = '0;
            crc_acc   = 8'h00;
            crc_rx    = 8'h00;
            out_due_q.delete();
        end else begin
            // output side first: a transfer can never answer a byte taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (out_due_q.size() == 0) begin
                    flag_mismatch("transfer with nothing waiting", i_m_tdata, 0);
                end else begin
                    want = out_due_q.pop_front();
                    if (i_m_tdata !== want.data) begin
                        flag_mismatch("out_byte", i_m_tdata, want.data);
                    end
                    if (i_m_tuser !== want.status) begin
                        flag_mismatch("frame_status", i_m_tuser, want.status);
                    end
                    if (i_m_tlast !== want.last) begin
                        flag_mismatch("frame_last", i_m_tlast, want.last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_START_MARKER: start_mk = i_cfg_data;
                    REG_END_MARKER:   end_mk   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= out_due_q.size();
    end

endmodule

[sim/tb_crc8_checked_frame_deframer.sv]
`timescale 1ns / 1ps
module tb_crc8_checked_frame_deframer;
    import cdfr_pkg::*;

    localparam logic [1:0] REG_SPARE_A  = 2'd2;
    localparam logic [1:0] REG_SPARE_B  = 2'd3;
    localparam int         PHASE_BYTES  = 36;
    localparam int         FLUSH_BYTES  = 36;
    localparam int         DRAIN_CYCLES = 120;
    localparam int         HOLD_AFTER   = 4;
    localparam int         HOLD_CYCLES  = 800;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         pending;
    int         err_count;

    logic [7:0] start_mk;
    logic [7:0] end_mk;
    logic [7:0] payload_buf[$];
    bit         sender_fast;
    int         rx_sent;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    crc8_checked_frame_deframer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    crc8_frame_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (err_count)
    );

    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        repeat (8) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // random byte from lo..255 that differs from both given values
    function automatic logic [7:0] pick_byte(input int lo, input logic [7:0] a,
                                             input logic [7:0] b);
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(lo, 255));
        end while (v == a || v == b);
        return v;
    endfunction

    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        rx_sent++;
    endtask

    task automatic send_frame(input logic [7:0] crc_flip, input logic [7:0] closer);
        logic [7:0] crc;
        crc = 8'h00;
        send_rx(start_mk);
        send_rx(8'(payload_buf.size()));
        foreach (payload_buf[i]) begin
            crc = crc8_fold(crc, payload_buf[i]);
            send_rx(payload_buf[i]);
        end
        send_rx(crc ^ crc_flip);
        send_rx(closer);
    endtask

    task automatic random_burst(input int goal);
        int pick;
        int len;
        rx_sent = 0;
        while (rx_sent < goal) begin
            sender_fast = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
            end else if (pick < 13) begin
                send_rx(start_mk);
                send_rx(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    len = $urandom_range(0, 6);
                end else if (pick < 92) begin
                    len = $urandom_range(7, MAX_PAYLOAD - 1);
                end else begin
                    len = MAX_PAYLOAD;
                end
                payload_buf.delete();
                repeat (len) payload_buf.push_back(8'($urandom));
                send_frame(($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)),
                           ($urandom_range(0, 99) < 88) ? end_mk : pick_byte(0, end_mk, end_mk));
            end
        end
        sender_fast = 1'b0;
    endtask

    // push the parser back to hunting, then let every result drain out
    task automatic settle();
        repeat (FLUSH_BYTES) send_rx(pick_byte(MAX_PAYLOAD + 1, start_mk, end_mk));
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_MARKER;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= REG_END_MARKER;
        cfg_data  <= e;
        @(posedge clk);
        // unused indices must leave both markers alone
        cfg_index <= REG_SPARE_A;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we   <= 1'b0;
        start_mk = s;
        end_mk   = e;
    endtask

    initial begin
        logic [7:0] mk;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= REG_START_MARKER;
        cfg_data  <= 8'h00;
        start_mk  = 8'h02;
        end_mk    = 8'h03;
        sender_fast = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames on the reset markers
        payload_buf.delete();
        send_frame(8'h00, end_mk);                  // empty frame, CRC of nothing is 0
        send_rx(start_mk);
        send_rx(8'(MAX_PAYLOAD + 1));               // one past capacity
        send_rx(start_mk);
        send_rx(8'hFF);
        payload_buf = '{8'h00};
        send_frame(8'h01, end_mk);                  // CRC mismatch
        payload_buf = '{8'hFF};
        send_frame(8'h80, start_mk);                // bad CRC and start value in end slot
        payload_buf = '{start_mk, end_mk};
        send_frame(8'h00, end_mk);                  // marker values as payload
        random_burst(PHASE_BYTES);
        settle();

        set_markers(8'h00, 8'hFF);
        random_burst(PHASE_BYTES);
        settle();

        set_markers(8'hFF, 8'h00);
        random_burst(PHASE_BYTES);
        settle();

        mk = 8'($urandom);
        set_markers(mk, pick_byte(0, mk, mk));
        random_burst(PHASE_BYTES);
        settle();

        // start and end share one value
        mk = 8'($urandom);
        set_markers(mk, mk);
        random_burst(PHASE_BYTES);
        settle();

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // output side: random stalls, bursts of back-to-back transfers, one long hold-off
    initial begin
        int  stall;
        int  accepted;
        bit  fast;
        m_tready <= 1'b0;
        accepted = 0;
        fast     = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (accepted % 40 == 0) begin
                fast = ($urandom_range(0, 2) == 0);
            end
            stall = fast ? 0 : $urandom_range(0, 13);
            if (accepted == HOLD_AFTER) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            accepted++;
        end
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
